@@ hw/rtl/mbld_pkg.sv @@
// ----------------------------------------------------------------------------
// mbld_pkg
// Shared constants and item types for the multi-button lockout debouncer.
// ----------------------------------------------------------------------------
package mbld_pkg;

    // Number of physical button pins in one sample.
    localparam int PIN_COUNT = 12;

    // Default number of debounced buttons.
    localparam int BUTTON_COUNT_DEF = 12;

    // Field widths.
    localparam int TIME_W  = 32;
    localparam int DEB_W   = 16;
    localparam int QIDX_W  = 4;

    // Lockout window after reset, in milliseconds.
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd25;

    // One input item as held in the input register.
    typedef struct packed {
        logic [TIME_W-1:0]    now_ms;
        logic [PIN_COUNT-1:0] raw_levels;
        logic [QIDX_W-1:0]    query_button;
        logic [TIME_W-1:0]    query_duration;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [PIN_COUNT-1:0] pressed_mask;
        logic [PIN_COUNT-1:0] changed_mask;
        logic [PIN_COUNT-1:0] just_pressed_mask;
        logic [PIN_COUNT-1:0] just_released_mask;
        logic                 query_found;
        logic                 query_held_pressed;
        logic                 query_held_released;
        logic [TIME_W-1:0]    query_last_change;
    } result_t;

endpackage

@@ hw/rtl/mbld_in_stage.sv @@
// ----------------------------------------------------------------------------
// mbld_in_stage
// Input register: captures one sample item and holds it until the update
// stage can pass its result on.
// ----------------------------------------------------------------------------
module mbld_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  mbld_pkg::item_t in_item,
    input  logic            down_ready,
    output logic            item_valid,
    output mbld_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    mbld_pkg::item_t item_reg;
    logic            load;

    // The register frees up whenever its item moves on or it is empty.
    assign in_stall = valid_reg && !down_ready;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (!in_stall)
        begin
            valid_next = in_valid;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ hw/rtl/mbld_update.sv @@
// ----------------------------------------------------------------------------
// mbld_update
// Per-button lockout state and the per-item update: decides for every
// button whether the pin is taken, records change times and answers the
// hold-time query.
// ----------------------------------------------------------------------------
module mbld_update
#(
    parameter int BUTTON_COUNT = mbld_pkg::BUTTON_COUNT_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  mbld_pkg::item_t             item,
    input  logic [mbld_pkg::DEB_W-1:0]  debounce_ms,
    output mbld_pkg::result_t           result
);

    localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam int PC    = mbld_pkg::PIN_COUNT;
    localparam int TW    = mbld_pkg::TIME_W;

    logic [BUTTON_COUNT-1:0] pressed_reg;
    logic [BUTTON_COUNT-1:0] pressed_next;
    logic [BUTTON_COUNT-1:0] changed;
    logic [BUTTON_COUNT-1:0] pin_low;
    logic [BUTTON_COUNT-1:0] locked;
    logic [TW-1:0]           time_reg [BUTTON_COUNT];

    logic [TW-1:0]           lockout;
    logic                    found;
    logic [IDX_W-1:0]        qidx;
    logic [TW-1:0]           old_time;
    logic                    old_long;
    logic                    q_changed;
    logic                    q_pressed;
    logic                    long_enough;
    logic [TW-1:0]           last_time;

    assign lockout = TW'(debounce_ms);

    // Per-button lockout check and pin decision; buttons past the pins read low.
    for (genvar i = 0; i < BUTTON_COUNT; i++)
    begin : g_btn
        if (i < PC)
        begin : g_pin
            assign pin_low[i] = !item.raw_levels[i];
        end
        else
        begin : g_nopin
            assign pin_low[i] = 1'b1;
        end

        assign locked[i]       = (item.now_ms - time_reg[i]) < lockout;
        assign pressed_next[i] = locked[i] ? pressed_reg[i] : pin_low[i];
        assign changed[i]      = !locked[i] && (pin_low[i] != pressed_reg[i]);
    end

    // Query: the stored time is read in parallel with the lockout checks; a
    // button that changes on this sample has a hold time of zero.
    assign found     = (32'(item.query_button) < BUTTON_COUNT);
    assign qidx      = IDX_W'(item.query_button);
    assign old_time  = time_reg[qidx];
    assign old_long  = (item.now_ms - old_time) >= item.query_duration;
    assign q_changed = changed[qidx];
    assign q_pressed = pressed_next[qidx];

    always_comb
    begin
        if (q_changed)
        begin
            long_enough = (item.query_duration == '0);
            last_time   = item.now_ms;
        end
        else
        begin
            long_enough = old_long;
            last_time   = old_time;
        end
    end

    // Result masks carry only the pin positions.
    for (genvar j = 0; j < PC; j++)
    begin : g_mask
        if (j < BUTTON_COUNT)
        begin : g_used
            assign result.pressed_mask[j]       = pressed_next[j];
            assign result.changed_mask[j]       = changed[j];
            assign result.just_pressed_mask[j]  = changed[j] && pressed_next[j];
            assign result.just_released_mask[j] = changed[j] && !pressed_next[j];
        end
        else
        begin : g_unused
            assign result.pressed_mask[j]       = 1'b0;
            assign result.changed_mask[j]       = 1'b0;
            assign result.just_pressed_mask[j]  = 1'b0;
            assign result.just_released_mask[j] = 1'b0;
        end
    end

    assign result.query_found         = found;
    assign result.query_held_pressed  = found && q_pressed && long_enough;
    assign result.query_held_released = found && !q_pressed && long_enough;
    assign result.query_last_change   = found ? last_time : '0;

    // Debounced state and change times advance once per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= '0;
            for (int k = 0; k < BUTTON_COUNT; k++)
            begin
                time_reg[k] <= '0;
            end
        end
        else if (fire)
        begin
            pressed_reg <= pressed_next;
            for (int k = 0; k < BUTTON_COUNT; k++)
            begin
                if (changed[k])
                begin
                    time_reg[k] <= item.now_ms;
                end
            end
        end
    end

endmodule

@@ hw/rtl/mbld_out_stage.sv @@
// ----------------------------------------------------------------------------
// mbld_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module mbld_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  mbld_pkg::result_t result_in,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_stall,
    output mbld_pkg::result_t result_out
);

    logic              valid_reg;
    logic              valid_next;
    mbld_pkg::result_t result_reg;

    // The register can load when empty or when its item leaves this cycle.
    assign ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (ready)
        begin
            valid_next = fire;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

@@ hw/rtl/multi_button_lockout_debouncer.sv @@
// ----------------------------------------------------------------------------
// multi_button_lockout_debouncer
// Lockout debouncer for active-low buttons with a hold-time query.
//
//   Channel  Direction  Handshake          Payload
//   in       input      in_valid/in_stall  now_ms, raw_levels, query_button,
//                                          query_duration
//   out      output     out_valid/out_stall pressed/changed/just_pressed/
//                                          just_released masks, query fields
//   cfg      input      cfg_we             cfg_wdata (debounce_ms)
//
// One item per cycle while out_stall is low; an item that is taken is held in
// the input register, then the state update writes its result into the result
// register, from which it leaves when out_stall is low.
// Reset clears the valid flags, all button states to released, all change
// times to zero and the lockout window to 25 ms.
// While the result register is stalled, one more item is held in the input
// register before in_stall rises.
// ----------------------------------------------------------------------------
module multi_button_lockout_debouncer
#(
    parameter int BUTTON_COUNT = mbld_pkg::BUTTON_COUNT_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [mbld_pkg::TIME_W-1:0]     now_ms,
    input  logic [mbld_pkg::PIN_COUNT-1:0]  raw_levels,
    input  logic [mbld_pkg::QIDX_W-1:0]     query_button,
    input  logic [mbld_pkg::TIME_W-1:0]     query_duration,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mbld_pkg::PIN_COUNT-1:0]  pressed_mask,
    output logic [mbld_pkg::PIN_COUNT-1:0]  changed_mask,
    output logic [mbld_pkg::PIN_COUNT-1:0]  just_pressed_mask,
    output logic [mbld_pkg::PIN_COUNT-1:0]  just_released_mask,
    output logic                            query_found,
    output logic                            query_held_pressed,
    output logic                            query_held_released,
    output logic [mbld_pkg::TIME_W-1:0]     query_last_change,

    input  logic                            cfg_we,
    input  logic [mbld_pkg::DEB_W-1:0]      cfg_wdata
);

    mbld_pkg::item_t               in_item;
    mbld_pkg::item_t               item;
    mbld_pkg::result_t             result_next;
    mbld_pkg::result_t             result;
    logic                          item_valid;
    logic                          down_ready;
    logic                          fire;
    logic [mbld_pkg::DEB_W-1:0]    debounce_reg;

    // Lockout window register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= mbld_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            debounce_reg <= cfg_wdata;
        end
    end

    // Gather the input fields into one item.
    assign in_item.now_ms         = now_ms;
    assign in_item.raw_levels     = raw_levels;
    assign in_item.query_button   = query_button;
    assign in_item.query_duration = query_duration;

    mbld_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .down_ready (down_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    // The held item is processed when the result register can take it.
    assign fire = item_valid && down_ready;

    mbld_update #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_update
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (item),
        .debounce_ms (debounce_reg),
        .result      (result_next)
    );

    mbld_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .result_in  (result_next),
        .ready      (down_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_out (result)
    );

    // Spread the result item over the output ports.
    assign pressed_mask        = result.pressed_mask;
    assign changed_mask        = result.changed_mask;
    assign just_pressed_mask   = result.just_pressed_mask;
    assign just_released_mask  = result.just_released_mask;
    assign query_found         = result.query_found;
    assign query_held_pressed  = result.query_held_pressed;
    assign query_held_released = result.query_held_released;
    assign query_last_change   = result.query_last_change;

endmodule
